### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the RTL. They compile to nothing when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked at each rising edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Checked at each rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

### rtl/core/udph_pkg.sv
// ----------------------------------------------------------------------------
// udph_pkg
// Types and constants shared by the UDP/IPv4 frame header builder.
// ----------------------------------------------------------------------------
package udph_pkg;

  localparam logic [15:0] MAX_PAYLOAD   = 16'd65507;
  localparam int          NUM_WORDS     = 6;
  localparam logic [2:0]  LAST_WORD_IDX = 3'(NUM_WORDS - 1);
  localparam logic [3:0]  WORD_BYTES    = 4'd8;
  localparam logic [3:0]  LAST_BYTES    = 4'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_SOURCE_IP   = 3'd0;
  localparam logic [2:0] REG_DEST_IP     = 3'd1;
  localparam logic [2:0] REG_SOURCE_PORT = 3'd2;
  localparam logic [2:0] REG_DEST_PORT   = 3'd3;

  localparam logic [31:0] RESET_IP   = 32'hAB00_0001;
  localparam logic [15:0] RESET_PORT = 16'h0000;

  // Fixed header constants.
  localparam logic [15:0] IPV4_HDR_LEN  = 16'd20;
  localparam logic [15:0] UDP_HDR_LEN   = 16'd8;
  localparam logic [15:0] IP_TOTAL_BASE = IPV4_HDR_LEN + UDP_HDR_LEN;
  localparam logic [15:0] IP_VER_IHL    = 16'h4500;
  localparam logic [7:0]  IP_TTL        = 8'd64;
  localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
  localparam logic [15:0] IP_TTL_PROTO  = {IP_TTL, IP_PROTO_UDP};
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] CSUM_ONES     = 16'hFFFF;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       carries_byte;
    logic       closes_packet;
  } in_t;

  typedef struct packed {
    logic [63:0] header_word;
    logic [3:0]  bytes_valid;
    logic        last_word;
    logic        payload_truncated;
  } out_t;

  typedef struct packed {
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
  } cfg_t;

  // Packet totals captured when a packet closes.
  typedef struct packed {
    logic [31:0] sum;
    logic [7:0]  pend;
    logic        odd;
    logic [15:0] count;
    logic        ovf;
  } close_t;

  typedef struct packed {
    logic [NUM_WORDS-1:0][63:0] words;
    logic                       truncated;
  } hdr_t;

  // Final ones'-complement step: an all-ones sum is sent unchanged.
  function automatic logic [15:0] csum_finish(input logic [15:0] s);
    logic [15:0] r;
    r = (s == CSUM_ONES) ? CSUM_ONES : ~s;
    return r;
  endfunction

endpackage

### rtl/core/udph_accum.sv
// ----------------------------------------------------------------------------
// udph_accum
// Per-byte running checksum, byte count and odd-byte holder. Captures the
// packet totals into a one-entry close register when a packet ends.
// ----------------------------------------------------------------------------
module udph_accum (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_acc,
  input  udph_pkg::in_t     in_data,
  input  logic              next_ready,
  output logic              close_valid,
  output udph_pkg::close_t  close_data
);

  logic [31:0] sum_r, sum_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic        odd_r, odd_nxt;
  logic        ovf_r, ovf_nxt;
  logic        close_v_r, close_v_nxt;
  udph_pkg::close_t close_r, close_nxt;

  // Byte update; a closing item sees the byte first.
  always_comb begin
    sum_nxt   = sum_r;
    count_nxt = count_r;
    pend_nxt  = pend_r;
    odd_nxt   = odd_r;
    ovf_nxt   = ovf_r;
    if (in_data.carries_byte) begin
      if (count_r >= udph_pkg::MAX_PAYLOAD) begin
        ovf_nxt = 1'b1;
      end else begin
        if (odd_r) begin
          sum_nxt  = sum_r + {16'd0, pend_r, in_data.payload_byte};
          odd_nxt  = 1'b0;
          pend_nxt = 8'd0;
        end else begin
          pend_nxt = in_data.payload_byte;
          odd_nxt  = 1'b1;
        end
        count_nxt = count_r + 16'd1;
      end
    end
    close_nxt = '{sum: sum_nxt, pend: pend_nxt, odd: odd_nxt, count: count_nxt,
                  ovf: ovf_nxt};
    close_v_nxt = close_v_r && !next_ready;
    if (in_acc && in_data.closes_packet) begin
      close_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      count_r   <= '0;
      pend_r    <= '0;
      odd_r     <= 1'b0;
      ovf_r     <= 1'b0;
      close_v_r <= 1'b0;
    end else begin
      close_v_r <= close_v_nxt;
      if (in_acc) begin
        if (in_data.closes_packet) begin
          sum_r   <= '0;
          count_r <= '0;
          pend_r  <= '0;
          odd_r   <= 1'b0;
          ovf_r   <= 1'b0;
        end else begin
          sum_r   <= sum_nxt;
          count_r <= count_nxt;
          pend_r  <= pend_nxt;
          odd_r   <= odd_nxt;
          ovf_r   <= ovf_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_data.closes_packet) begin
      close_r <= close_nxt;
    end
  end

  assign close_valid = close_v_r;
  assign close_data  = close_r;

endmodule

### rtl/core/udph_csum.sv
// ----------------------------------------------------------------------------
// udph_csum
// Two-stage checksum pipeline: raw sums, then a first fold. The last fold,
// the complement and the header layout are built from the second stage.
// ----------------------------------------------------------------------------
module udph_csum (
  input  logic              clk,
  input  logic              rst_n,
  input  udph_pkg::cfg_t    cfg,
  input  logic              close_valid,
  input  udph_pkg::close_t  close_data,
  output logic              close_ready,
  output logic              hdr_valid,
  output udph_pkg::hdr_t    hdr_data,
  input  logic              hdr_ready
);

  // Address and port sums only change with configuration.
  logic [17:0] addr_sum_r, addr_sum_nxt;
  logic [18:0] aps_r, aps_nxt;

  logic        c1_v_r, c2_v_r;
  logic        c1_ready, c2_ready;
  logic [19:0] ip_raw_r, ip_raw_nxt;
  logic [32:0] udp_raw_r, udp_raw_nxt;
  logic [15:0] tot_len_r, udp_len_r;
  logic [15:0] tot_len_nxt, udp_len_nxt;
  logic        c1_ovf_r;

  logic [16:0] ip_s1_r, ip_s1_nxt;
  logic [17:0] udp_s1_r, udp_s1_nxt;
  logic [15:0] c2_tot_len_r, c2_udp_len_r;
  logic        c2_ovf_r;

  logic [15:0] ip_s2, udp_s3, ip_ck, udp_ck;
  logic [16:0] udp_s2;
  logic [15:0] odd_word;

  always_comb begin
    addr_sum_nxt = 18'(cfg.source_ip[31:16]) + 18'(cfg.source_ip[15:0])
                 + 18'(cfg.dest_ip[31:16]) + 18'(cfg.dest_ip[15:0]);
    aps_nxt = 19'(addr_sum_nxt) + 19'(cfg.source_port) + 19'(cfg.dest_port)
            + 19'(udph_pkg::IP_PROTO_UDP);
  end

  always_ff @(posedge clk) begin
    addr_sum_r <= addr_sum_nxt;
    aps_r      <= aps_nxt;
  end

  assign c2_ready    = !c2_v_r || hdr_ready;
  assign c1_ready    = !c1_v_r || c2_ready;
  assign close_ready = c1_ready;

  // Stage 1: raw sums. The UDP length enters twice (pseudo-header and header).
  always_comb begin
    tot_len_nxt = udph_pkg::IP_TOTAL_BASE + close_data.count;
    udp_len_nxt = udph_pkg::UDP_HDR_LEN + close_data.count;
    odd_word    = close_data.odd ? {close_data.pend, 8'h00} : 16'h0000;
    ip_raw_nxt  = 20'(udph_pkg::IP_VER_IHL) + 20'(udph_pkg::IP_TTL_PROTO)
                + 20'(tot_len_nxt) + 20'(addr_sum_r);
    udp_raw_nxt = 33'(close_data.sum) + 33'(odd_word) + 33'(aps_r)
                + 33'({udp_len_nxt, 1'b0});
  end

  // Stage 2: first fold.
  always_comb begin
    ip_s1_nxt  = 17'(ip_raw_r[15:0]) + 17'(ip_raw_r[19:16]);
    udp_s1_nxt = 18'(udp_raw_r[15:0]) + 18'(udp_raw_r[32:16]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r <= 1'b0;
      c2_v_r <= 1'b0;
    end else begin
      if (c1_ready) begin
        c1_v_r <= close_valid;
      end
      if (c2_ready) begin
        c2_v_r <= c1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c1_ready && close_valid) begin
      ip_raw_r  <= ip_raw_nxt;
      udp_raw_r <= udp_raw_nxt;
      tot_len_r <= tot_len_nxt;
      udp_len_r <= udp_len_nxt;
      c1_ovf_r  <= close_data.ovf;
    end
    if (c2_ready && c1_v_r) begin
      ip_s1_r      <= ip_s1_nxt;
      udp_s1_r     <= udp_s1_nxt;
      c2_tot_len_r <= tot_len_r;
      c2_udp_len_r <= udp_len_r;
      c2_ovf_r     <= c1_ovf_r;
    end
  end

  // Last folds, complement and header layout.
  always_comb begin
    ip_s2  = ip_s1_r[15:0] + 16'(ip_s1_r[16]);
    udp_s2 = 17'(udp_s1_r[15:0]) + 17'(udp_s1_r[17:16]);
    udp_s3 = udp_s2[15:0] + 16'(udp_s2[16]);
    ip_ck  = udph_pkg::csum_finish(ip_s2);
    udp_ck = udph_pkg::csum_finish(udp_s3);

    hdr_data.words[0] = {48'hFFFF_FFFF_FFFF, 16'h0000};
    hdr_data.words[1] = {32'h0000_0000, udph_pkg::ETH_TYPE_IPV4, udph_pkg::IP_VER_IHL};
    hdr_data.words[2] = {c2_tot_len_r, 16'h0000, 16'h0000, udph_pkg::IP_TTL_PROTO};
    hdr_data.words[3] = {ip_ck, cfg.source_ip, cfg.dest_ip[31:16]};
    hdr_data.words[4] = {cfg.dest_ip[15:0], cfg.source_port, cfg.dest_port,
                         c2_udp_len_r};
    hdr_data.words[5] = {udp_ck, 48'h0};
    hdr_data.truncated = c2_ovf_r;
  end

  assign hdr_valid = c2_v_r;

endmodule

### rtl/core/udph_emit.sv
// ----------------------------------------------------------------------------
// udph_emit
// Holds one finished header and sends it out one 64-bit word per item.
// ----------------------------------------------------------------------------
module udph_emit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            hdr_valid,
  input  udph_pkg::hdr_t  hdr_data,
  output logic            hdr_ready,
  output logic            out_valid,
  output udph_pkg::out_t  out_data,
  input  logic            out_ready
);

  udph_pkg::hdr_t buf_r;
  logic           buf_v_r, buf_v_nxt;
  logic [2:0]     idx_r, idx_nxt;
  logic           is_last, out_acc, load;

  assign is_last   = (idx_r == udph_pkg::LAST_WORD_IDX);
  assign out_acc   = buf_v_r && out_ready;
  assign hdr_ready = !buf_v_r || (out_acc && is_last);
  assign load      = hdr_valid && hdr_ready;

  always_comb begin
    buf_v_nxt = buf_v_r;
    idx_nxt   = idx_r;
    if (out_acc) begin
      if (is_last) begin
        buf_v_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
    if (load) begin
      buf_v_nxt = 1'b1;
      idx_nxt   = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_v_r <= 1'b0;
      idx_r   <= 3'd0;
    end else begin
      buf_v_r <= buf_v_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= hdr_data;
    end
  end

  always_comb begin
    out_data.header_word       = buf_r.words[idx_r];
    out_data.bytes_valid       = is_last ? udph_pkg::LAST_BYTES : udph_pkg::WORD_BYTES;
    out_data.last_word         = is_last;
    out_data.payload_truncated = buf_r.truncated;
  end

  assign out_valid = buf_v_r;

endmodule

### rtl/core/udp_ipv4_frame_header_builder.sv
// ----------------------------------------------------------------------------
// udp_ipv4_frame_header_builder
// Builds the 42-byte Ethernet/IPv4/UDP header for a payload byte stream.
// ----------------------------------------------------------------------------
// Usage: payload bytes enter on the in_ channel, one per item, with
// carries_byte marking a real byte. An item with closes_packet set ends the
// packet (its own byte, if any, counts first). The block then sends six items
// on the out_ channel, each one 64-bit header word with its first byte in the
// top bits: five full words and a last word holding the two UDP checksum
// bytes. Bytes beyond the payload limit are dropped and reported through
// payload_truncated on every word of that packet.
// Path: a closed packet passes the close register (loaded at the edge that
// accepts the closing item), then the two checksum stages and then the word
// buffer, from which the first header word is offered.
// Throughput: one input item per cycle unless stalled as below; the header
// of a packet goes out as six words, and the next packet's bytes keep
// flowing meanwhile. Input stalls, for any item, while a closed packet waits
// in the close register because the checksum stages and the word buffer
// still hold earlier headers that the receiver has not taken.
// Reset clears the packet state and the pipeline, and loads the default
// addresses (171.0.0.1) and zero ports. The cfg_ port writes one register
// per cycle and is meant to be used while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module udp_ipv4_frame_header_builder (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  udph_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output udph_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data
);

  udph_pkg::cfg_t   cfg_r;
  udph_pkg::close_t close_data;
  udph_pkg::hdr_t   hdr_data;
  logic             close_valid, close_ready;
  logic             hdr_valid, hdr_ready;
  logic             in_acc;

  // Configuration registers. Unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_ip   <= udph_pkg::RESET_IP;
      cfg_r.dest_ip     <= udph_pkg::RESET_IP;
      cfg_r.source_port <= udph_pkg::RESET_PORT;
      cfg_r.dest_port   <= udph_pkg::RESET_PORT;
    end else if (cfg_we) begin
      case (cfg_index)
        udph_pkg::REG_SOURCE_IP:   cfg_r.source_ip   <= cfg_data;
        udph_pkg::REG_DEST_IP:     cfg_r.dest_ip     <= cfg_data;
        udph_pkg::REG_SOURCE_PORT: cfg_r.source_port <= cfg_data[15:0];
        udph_pkg::REG_DEST_PORT:   cfg_r.dest_port   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // The accumulator always takes a byte; only the close register can block.
  assign in_ready = close_ready || !close_valid;
  assign in_acc   = in_valid && in_ready;

  udph_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_acc      (in_acc),
    .in_data     (in_data),
    .next_ready  (close_ready),
    .close_valid (close_valid),
    .close_data  (close_data)
  );

  udph_csum u_csum (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .close_valid (close_valid),
    .close_data  (close_data),
    .close_ready (close_ready),
    .hdr_valid   (hdr_valid),
    .hdr_data    (hdr_data),
    .hdr_ready   (hdr_ready)
  );

  udph_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .hdr_valid (hdr_valid),
    .hdr_data  (hdr_data),
    .hdr_ready (hdr_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_ready (out_ready)
  );

  // A header never stops halfway: after a taken word that is not the last,
  // the next word is offered at once.
  `ASSERT_CLK(a_header_contiguous, clk, rst_n, out_valid && out_ready && !out_data.last_word |=> out_valid)

  // The truncation flag belongs to the whole packet.
  `ASSERT_CLK(a_trunc_steady, clk, rst_n, out_valid && out_ready && !out_data.last_word |=> out_data.payload_truncated == $past(out_data.payload_truncated))

  // Only the final word is short.
  `ASSERT_CLK(a_word_bytes, clk, rst_n, out_valid |-> (out_data.last_word ? out_data.bytes_valid == udph_pkg::LAST_BYTES : out_data.bytes_valid == udph_pkg::WORD_BYTES))

  // Input only stalls behind a waiting packet close.
  `ASSERT_CLK(a_stall_cause, clk, rst_n, !in_ready |-> close_valid)

endmodule

### bench/tb_udp_ipv4_frame_header_builder.sv
// ----------------------------------------------------------------------------
// tb_udp_ipv4_frame_header_builder
// Self-checking bench for the UDP/IPv4 frame header builder. A directed table
// covers reset defaults, odd and even payloads, all-ones checksums and register
// extremes. Random packets follow under four idle mixes. An in-bench header
// predictor checks every output word field by field.
// ----------------------------------------------------------------------------
module tb_udp_ipv4_frame_header_builder;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles to let pass after the last expected word before touching registers
  // or ending the run. This covers the close register, the checksum stages and
  // the word buffer, plus any byte items still on their way in.
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_PHASES = 4;
  localparam int ITEMS_PER_PHASE = 90;
  // No register lives at this index, so a write to it must change nothing.
  localparam logic [2:0] REG_BEYOND = 3'd7;

  // Header for an empty packet under the reset addresses and ports. These
  // words can be worked out by hand, so they are typed in directly.
  localparam logic [0:5][63:0] RESET_HDR = {
    64'hFFFF_FFFF_FFFF_0000,
    64'h0000_0000_0800_4500,
    64'h001C_0000_0000_4011,
    64'h24CF_AB00_0001_AB00,
    64'h0001_0000_0000_0008,
    64'hA9DB_0000_0000_0000
  };

  typedef enum logic [1:0] {ROW_ITEM, ROW_RESET_HDR, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [7:0]  pbyte;
    logic        with_byte;
    logic        ends_pkt;
    logic [2:0]  idx;
    logic [31:0] val;
  } dir_row_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  udph_pkg::in_t   in_data = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  udph_pkg::out_t  out_data;
  logic  cfg_we = 1'b0;
  logic  [2:0] cfg_index = '0;
  logic  [31:0] cfg_data = '0;

  // Register copies as the bench believes the block holds them.
  logic [31:0] cur_sip;
  logic [31:0] cur_dip;
  logic [15:0] cur_sport;
  logic [15:0] cur_dport;

  // Packet state of the predictor.
  logic [31:0] pkt_sum;
  logic [15:0] pkt_count;
  logic [7:0]  odd_hi;
  logic        odd_pending;
  logic        pkt_dropped;

  // Header words predicted but not yet seen on the output, oldest first.
  udph_pkg::out_t header_due [$];

  int send_idle = 0;
  int recv_stall = 0;
  int mismatches = 0;
  int words_checked = 0;
  int items_sent = 0;
  int packets_closed = 0;
  int dropped_packets = 0;

  dir_row_t dir_table [0:29];

  udp_ipv4_frame_header_builder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Ones'-complement fold of a wide sum, then the final complement. A folded
  // sum of all ones is sent as it is rather than turned into zero.
  function automatic logic [15:0] finish_csum(input logic [63:0] s);
    while (s[63:16] != 0) s = {48'd0, s[15:0]} + {16'd0, s[63:16]};
    return (s[15:0] == 16'hFFFF) ? 16'hFFFF : ~s[15:0];
  endfunction

  function automatic void clear_packet_state();
    pkt_sum = '0;
    pkt_count = '0;
    odd_hi = '0;
    odd_pending = 1'b0;
    pkt_dropped = 1'b0;
  endfunction

  // Folds one accepted item into the packet state. On a closing item it lays
  // out the 42 header bytes and queues the six words that must come out.
  function automatic void predict_header(input udph_pkg::in_t it);
    logic [63:0] s;
    logic [15:0] tot_len;
    logic [15:0] udp_len;
    logic [15:0] ip_ck;
    logic [15:0] udp_ck;
    logic [7:0]  hb [0:47];
    udph_pkg::out_t r;
    if (it.carries_byte) begin
      if (pkt_count >= udph_pkg::MAX_PAYLOAD) begin
        // The payload is full: the byte is dropped and the packet is marked.
        pkt_dropped = 1'b1;
      end else begin
        if (odd_pending) begin
          pkt_sum = pkt_sum + {16'd0, odd_hi, it.payload_byte};
          odd_pending = 1'b0;
          odd_hi = '0;
        end else begin
          odd_hi = it.payload_byte;
          odd_pending = 1'b1;
        end
        pkt_count = pkt_count + 16'd1;
      end
    end
    if (!it.closes_packet) return;

    tot_len = udph_pkg::IP_TOTAL_BASE + pkt_count;
    udp_len = udph_pkg::UDP_HDR_LEN + pkt_count;
    s = 64'(udph_pkg::IP_VER_IHL) + tot_len + udph_pkg::IP_TTL_PROTO
        + cur_sip[31:16] + cur_sip[15:0] + cur_dip[31:16] + cur_dip[15:0];
    ip_ck = finish_csum(s);
    // A trailing odd byte counts as the high half of a zero-padded word.
    s = 64'(pkt_sum) + (odd_pending ? {48'd0, odd_hi, 8'd0} : 64'd0)
        + cur_sip[31:16] + cur_sip[15:0] + cur_dip[31:16] + cur_dip[15:0]
        + {8'd0, udph_pkg::IP_PROTO_UDP} + udp_len + cur_sport + cur_dport + udp_len;
    udp_ck = finish_csum(s);

    for (int i = 0; i < 48; i++) hb[i] = 8'h00;
    for (int i = 0; i < 6; i++) hb[i] = 8'hFF;
    {hb[12], hb[13]} = udph_pkg::ETH_TYPE_IPV4;
    {hb[14], hb[15]} = udph_pkg::IP_VER_IHL;
    {hb[16], hb[17]} = tot_len;
    hb[22] = udph_pkg::IP_TTL;
    hb[23] = udph_pkg::IP_PROTO_UDP;
    {hb[24], hb[25]} = ip_ck;
    {hb[26], hb[27], hb[28], hb[29]} = cur_sip;
    {hb[30], hb[31], hb[32], hb[33]} = cur_dip;
    {hb[34], hb[35]} = cur_sport;
    {hb[36], hb[37]} = cur_dport;
    {hb[38], hb[39]} = udp_len;
    {hb[40], hb[41]} = udp_ck;

    for (int k = 0; k < udph_pkg::NUM_WORDS; k++) begin
      r.header_word = '0;
      for (int i = 0; i < 8; i++) r.header_word = {r.header_word[55:0], hb[8 * k + i]};
      r.bytes_valid = (k == udph_pkg::NUM_WORDS - 1) ? udph_pkg::LAST_BYTES
                                                     : udph_pkg::WORD_BYTES;
      r.last_word = (k == udph_pkg::NUM_WORDS - 1);
      r.payload_truncated = pkt_dropped;
      header_due.push_back(r);
    end
    packets_closed++;
    if (pkt_dropped) dropped_packets++;
    clear_packet_state();
  endfunction

  task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // The receiver stalls at random, and every accepted word is compared with
  // the oldest prediction. Both handshake signals are read as they stood
  // just before the edge.
  always @(posedge clk) begin : out_side
    udph_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (header_due.size() == 0) begin
        $display("%0t ns: unexpected header word, expected none, actual %h",
                 $time, out_data.header_word);
        mismatches++;
      end else begin
        want = header_due.pop_front();
        check_field("header_word", want.header_word, out_data.header_word);
        check_field("bytes_valid", 64'(want.bytes_valid), 64'(out_data.bytes_valid));
        check_field("last_word", 64'(want.last_word), 64'(out_data.last_word));
        check_field("payload_truncated", 64'(want.payload_truncated),
                    64'(out_data.payload_truncated));
        words_checked++;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  // Presents one item after an optional random gap and holds it until the
  // block takes it. Valid stays high between items when no gap is drawn.
  task automatic push_item(input udph_pkg::in_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    predict_header(it);
  endtask

  // Waits until every predicted word has come out, then lets the pipeline
  // run dry so that a register write cannot land on a packet in flight.
  task automatic settle();
    in_valid <= 1'b0;
    while (header_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Drives one register write. The caller lowers the write enable once the
  // last write of a group has gone in.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      udph_pkg::REG_SOURCE_IP:   cur_sip = val;
      udph_pkg::REG_DEST_IP:     cur_dip = val;
      udph_pkg::REG_SOURCE_PORT: cur_sport = val[15:0];
      udph_pkg::REG_DEST_PORT:   cur_dport = val[15:0];
      default: ;
    endcase
  endtask

  // Zero, all ones or a random value, so that the extremes turn up often.
  function automatic logic [31:0] pick_cfg_value();
    case ($urandom_range(3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Port registers get random upper bits, which the block must ignore. Now
  // and then a write goes to an index with no register behind it.
  task automatic program_regs();
    write_reg(udph_pkg::REG_SOURCE_IP, pick_cfg_value());
    write_reg(udph_pkg::REG_DEST_IP, pick_cfg_value());
    write_reg(udph_pkg::REG_SOURCE_PORT,
              {16'($urandom_range(16'hFFFF)), 16'(pick_cfg_value())});
    write_reg(udph_pkg::REG_DEST_PORT,
              {16'($urandom_range(16'hFFFF)), 16'(pick_cfg_value())});
    if ($urandom_range(1)) write_reg(3'($urandom_range(7, 4)), $urandom);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    dir_row_t row;
    udph_pkg::in_t it;
    logic     quiet;
    int       counted;
    int       idle_mix [0:RANDOM_PHASES-1][0:1];
    int       base;

    idle_mix = '{'{0, 0}, '{78, 0}, '{0, 78}, '{38, 38}};

    // Directed rows. Register rows are applied only once the block is idle.
    dir_table = '{
      '{ROW_RESET_HDR, 8'h00, 1'b0, 1'b1, udph_pkg::REG_SOURCE_IP, 32'h0},  // empty, reset regs
      '{ROW_ITEM, 8'h00, 1'b0, 1'b0, udph_pkg::REG_SOURCE_IP, 32'h0},  // neither byte nor close
      '{ROW_ITEM, 8'hFF, 1'b1, 1'b0, udph_pkg::REG_SOURCE_IP, 32'h0},
      '{ROW_ITEM, 8'h00, 1'b1, 1'b1, udph_pkg::REG_SOURCE_IP, 32'h0},  // byte and close together
      '{ROW_ITEM, 8'hA5, 1'b1, 1'b1, udph_pkg::REG_SOURCE_IP, 32'h0},  // one-byte packet
      '{ROW_ITEM, 8'hFF, 1'b1, 1'b0, udph_pkg::REG_SOURCE_IP, 32'h0},
      '{ROW_ITEM, 8'hFF, 1'b1, 1'b0, udph_pkg::REG_SOURCE_IP, 32'h0},
      '{ROW_ITEM, 8'hFF, 1'b1, 1'b0, udph_pkg::REG_SOURCE_IP, 32'h0},
      '{ROW_ITEM, 8'h00, 1'b0, 1'b1, udph_pkg::REG_SOURCE_IP, 32'h0},  // odd byte left waiting
      '{ROW_ITEM, 8'h5A, 1'b1, 1'b0, udph_pkg::REG_SOURCE_IP, 32'h0},
      '{ROW_ITEM, 8'h00, 1'b0, 1'b0, udph_pkg::REG_SOURCE_IP, 32'h0},
      '{ROW_ITEM, 8'hC3, 1'b1, 1'b0, udph_pkg::REG_SOURCE_IP, 32'h0},
      '{ROW_ITEM, 8'h00, 1'b0, 1'b1, udph_pkg::REG_SOURCE_IP, 32'h0},
      // These values make both folded sums come to all ones.
      '{ROW_REG, 8'h00, 1'b0, 1'b0, udph_pkg::REG_SOURCE_IP, 32'h7AD2_0000},
      '{ROW_REG, 8'h00, 1'b0, 1'b0, udph_pkg::REG_DEST_IP, 32'h0000_0000},
      '{ROW_REG, 8'h00, 1'b0, 1'b0, udph_pkg::REG_SOURCE_PORT, 32'h0000_850C},
      '{ROW_REG, 8'h00, 1'b0, 1'b0, udph_pkg::REG_DEST_PORT, 32'h0000_0000},
      '{ROW_ITEM, 8'h00, 1'b0, 1'b1, udph_pkg::REG_SOURCE_IP, 32'h0},
      '{ROW_REG, 8'h00, 1'b0, 1'b0, udph_pkg::REG_SOURCE_IP, 32'hFFFF_FFFF},
      '{ROW_REG, 8'h00, 1'b0, 1'b0, udph_pkg::REG_DEST_IP, 32'hFFFF_FFFF},
      '{ROW_REG, 8'h00, 1'b0, 1'b0, udph_pkg::REG_SOURCE_PORT, 32'hFFFF_FFFF},
      '{ROW_REG, 8'h00, 1'b0, 1'b0, udph_pkg::REG_DEST_PORT, 32'hFFFF_FFFF},
      '{ROW_ITEM, 8'hFF, 1'b1, 1'b0, udph_pkg::REG_SOURCE_IP, 32'h0},
      '{ROW_ITEM, 8'hFF, 1'b1, 1'b1, udph_pkg::REG_SOURCE_IP, 32'h0},
      '{ROW_REG, 8'h00, 1'b0, 1'b0, udph_pkg::REG_SOURCE_IP, 32'h0000_0000},
      '{ROW_REG, 8'h00, 1'b0, 1'b0, udph_pkg::REG_DEST_IP, 32'h0000_0000},
      '{ROW_REG, 8'h00, 1'b0, 1'b0, udph_pkg::REG_SOURCE_PORT, 32'hFFFF_0000},  // upper masked
      '{ROW_REG, 8'h00, 1'b0, 1'b0, udph_pkg::REG_DEST_PORT, 32'hFFFF_0000},
      '{ROW_REG, 8'h00, 1'b0, 1'b0, REG_BEYOND, 32'hFFFF_FFFF},       // must be ignored
      '{ROW_ITEM, 8'h00, 1'b1, 1'b1, udph_pkg::REG_SOURCE_IP, 32'h0}
    };

    cur_sip = udph_pkg::RESET_IP;
    cur_dip = udph_pkg::RESET_IP;
    cur_sport = udph_pkg::RESET_PORT;
    cur_dport = udph_pkg::RESET_PORT;
    clear_packet_state();

    // Reset is held from the start and released at an edge.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: quiet handshakes first so that the table reads plainly.
    quiet = 1'b1;
    foreach (dir_table[n]) begin
      row = dir_table[n];
      if (row.kind == ROW_REG) begin
        if (!quiet) settle();
        quiet = 1'b1;
        write_reg(row.idx, row.val);
        if (n == $high(dir_table) || dir_table[n + 1].kind != ROW_REG) cfg_we <= 1'b0;
      end else begin
        quiet = 1'b0;
        it.payload_byte = row.pbyte;
        it.carries_byte = row.with_byte;
        it.closes_packet = row.ends_pkt;
        push_item(it);
        if (row.kind == ROW_RESET_HDR) begin
          // Replace the predicted words with the hand-worked ones.
          base = header_due.size() - udph_pkg::NUM_WORDS;
          for (int k = 0; k < udph_pkg::NUM_WORDS; k++) begin
            udph_pkg::out_t tmp;
            tmp = header_due[base + k];
            tmp.header_word = RESET_HDR[k];
            header_due[base + k] = tmp;
          end
        end
      end
    end

    // Random packets under each idle mix. Most items carry a byte and about
    // one in eight closes, so packets stay short and headers come often.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      send_idle = idle_mix[p][0];
      recv_stall = idle_mix[p][1];
      program_regs();
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        it.payload_byte = 8'($urandom);
        it.carries_byte = ($urandom_range(99) < 85);
        it.closes_packet = ($urandom_range(99) < 12);
        push_item(it);
        if (it.carries_byte || it.closes_packet) counted++;
      end
      // No packet stays open across a register change.
      if (pkt_count != 0 || pkt_dropped) begin
        it.payload_byte = 8'($urandom);
        it.carries_byte = $urandom_range(1);
        it.closes_packet = 1'b1;
        push_item(it);
      end
    end

    settle();
    $display("Sent %0d items in %0d packets, %0d of them with dropped bytes.",
             items_sent, packets_closed, dropped_packets);
    $display("Checked %0d header words across reset, extreme and random registers.",
             words_checked);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Safety net: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Timed out with %0d header words still expected.", header_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
